// ===== design/lob_pkg.sv =====
// Package for the limit order book matcher.
// Holds the transaction structs, book entry type, command and result codes,
// controller states and the controller/datapath interface structs.
`default_nettype none
package lob_pkg;

    localparam int BOOK_DEPTH = 16;
    localparam int IDX_W      = $clog2(BOOK_DEPTH);
    localparam int CNT_W      = $clog2(BOOK_DEPTH + 1);

    localparam logic [1:0] CMD_SUBMIT = 2'd0;
    localparam logic [1:0] CMD_LIST   = 2'd1;
    localparam logic [1:0] CMD_CANCEL = 2'd2;

    localparam logic [3:0] KIND_ID        = 4'd0;
    localparam logic [3:0] KIND_TRADE     = 4'd1;
    localparam logic [3:0] KIND_DONE      = 4'd2;
    localparam logic [3:0] KIND_DROPPED   = 4'd3;
    localparam logic [3:0] KIND_BUY_LIST  = 4'd4;
    localparam logic [3:0] KIND_SELL_LIST = 4'd5;
    localparam logic [3:0] KIND_LIST_END  = 4'd6;
    localparam logic [3:0] KIND_CANCELLED = 4'd7;
    localparam logic [3:0] KIND_NOT_FOUND = 4'd8;

    localparam logic SIDE_BUY  = 1'b0;
    localparam logic SIDE_SELL = 1'b1;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [13:0] ticker;
        logic [16:0] limit_price;
        logic [15:0] order_quantity;
        logic        side;
        logic [15:0] target_id;
    } t_in;

    typedef struct packed {
        logic [3:0]  kind;
        logic [15:0] order_id;
        logic [15:0] counter_id;
        logic [13:0] entry_stock;
        logic [17:0] entry_price;
        logic [15:0] entry_quantity;
        logic        entry_side;
        logic        last;
    } t_out;

    typedef struct packed {
        logic [15:0] id;
        logic [13:0] stock;
        logic [16:0] price;
        logic [15:0] qty;
    } t_entry;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUB_ID,
        ST_SUB_WALK,
        ST_SUB_FIN,
        ST_SUB_SCAN,
        ST_SUB_INS,
        ST_SUB_DONE,
        ST_SUB_DROP,
        ST_LIST_BUY,
        ST_LIST_SELL,
        ST_LIST_END,
        ST_CAN_BUY,
        ST_CAN_SELL,
        ST_CAN_NF
    } t_state;

    typedef struct packed {
        logic       load;
        logic       book;
        logic       clr;
        logic       inc;
        logic       remove;
        logic       insert;
        logic       fill;
        logic       emit;
        logic [3:0] kind;
        logic       last;
    } t_ctl;

    typedef struct packed {
        logic [1:0] in_cmd;
        logic       qty_zero;
        logic       side;
        logic       in_range;
        logic       crosses;
        logic       stock_eq;
        logic       id_eq;
        logic       ahead;
        logic       rem_zero;
        logic       own_full;
        logic       fill_all;
        logic       out_free;
    } t_sts;

endpackage
`default_nettype wire

// ===== design/lob_ctrl.sv =====
// Controller state machine of the limit order book matcher.
// Sequences submit, list and cancel commands; depends on lob_pkg.
`default_nettype none
module lob_ctrl
    import lob_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_in_valid,
    output logic o_in_stall,
    input  t_sts i_sts,
    output t_ctl o_ctl
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_stall = 1'b1;
        o_ctl      = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_ctl.load = 1'b1;
                    case (i_sts.in_cmd)
                        CMD_SUBMIT: n_state = ST_SUB_ID;
                        CMD_LIST:   n_state = ST_LIST_BUY;
                        CMD_CANCEL: n_state = ST_CAN_BUY;
                        default:    n_state = ST_IDLE;
                    endcase
                end
            end
            ST_SUB_ID: begin
                if (i_sts.out_free) begin
                    o_ctl.emit = 1'b1;
                    o_ctl.kind = KIND_ID;
                    n_state = i_sts.qty_zero ? ST_SUB_DONE : ST_SUB_WALK;
                end
            end
            ST_SUB_WALK: begin
                o_ctl.book = ~i_sts.side;
                if (i_sts.rem_zero || !i_sts.in_range || !i_sts.crosses) begin
                    n_state = ST_SUB_FIN;
                end else if (!i_sts.stock_eq) begin
                    o_ctl.inc = 1'b1;
                end else if (i_sts.out_free) begin
                    o_ctl.emit   = 1'b1;
                    o_ctl.kind   = KIND_TRADE;
                    o_ctl.fill   = 1'b1;
                    o_ctl.remove = i_sts.fill_all;
                    o_ctl.inc    = ~i_sts.fill_all;
                end
            end
            ST_SUB_FIN: begin
                o_ctl.clr = 1'b1;
                if (i_sts.rem_zero) begin
                    n_state = ST_SUB_DONE;
                end else if (i_sts.own_full) begin
                    n_state = ST_SUB_DROP;
                end else begin
                    n_state = ST_SUB_SCAN;
                end
            end
            ST_SUB_SCAN: begin
                o_ctl.book = i_sts.side;
                if (i_sts.in_range && !i_sts.ahead) begin
                    o_ctl.inc = 1'b1;
                end else begin
                    n_state = ST_SUB_INS;
                end
            end
            ST_SUB_INS: begin
                o_ctl.book = i_sts.side;
                if (i_sts.out_free) begin
                    o_ctl.insert = 1'b1;
                    o_ctl.emit   = 1'b1;
                    o_ctl.kind   = KIND_DONE;
                    o_ctl.last   = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_SUB_DONE, ST_SUB_DROP: begin
                if (i_sts.out_free) begin
                    o_ctl.emit = 1'b1;
                    o_ctl.kind = (r_state == ST_SUB_DONE) ? KIND_DONE : KIND_DROPPED;
                    o_ctl.last = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_LIST_BUY, ST_LIST_SELL: begin
                o_ctl.book = (r_state == ST_LIST_SELL);
                if (!i_sts.in_range) begin
                    o_ctl.clr = 1'b1;
                    n_state = (r_state == ST_LIST_BUY) ? ST_LIST_SELL : ST_LIST_END;
                end else if (!i_sts.stock_eq) begin
                    o_ctl.inc = 1'b1;
                end else if (i_sts.out_free) begin
                    o_ctl.emit = 1'b1;
                    o_ctl.kind = (r_state == ST_LIST_BUY) ? KIND_BUY_LIST : KIND_SELL_LIST;
                    o_ctl.inc  = 1'b1;
                end
            end
            ST_LIST_END: begin
                if (i_sts.out_free) begin
                    o_ctl.emit = 1'b1;
                    o_ctl.kind = KIND_LIST_END;
                    o_ctl.last = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_CAN_BUY, ST_CAN_SELL: begin
                o_ctl.book = (r_state == ST_CAN_SELL);
                if (!i_sts.in_range) begin
                    o_ctl.clr = 1'b1;
                    n_state = (r_state == ST_CAN_BUY) ? ST_CAN_SELL : ST_CAN_NF;
                end else if (!i_sts.id_eq) begin
                    o_ctl.inc = 1'b1;
                end else if (i_sts.out_free) begin
                    o_ctl.emit   = 1'b1;
                    o_ctl.kind   = KIND_CANCELLED;
                    o_ctl.last   = 1'b1;
                    o_ctl.remove = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_CAN_NF: begin
                if (i_sts.out_free) begin
                    o_ctl.emit = 1'b1;
                    o_ctl.kind = KIND_NOT_FOUND;
                    o_ctl.last = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule
`default_nettype wire

// ===== design/lob_dp.sv =====
// Datapath of the limit order book matcher: both books, counts, order id,
// walk index, remaining quantity and the output register; depends on lob_pkg.
`default_nettype none
module lob_dp
    import lob_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  t_in  i_in,
    input  wire  i_out_stall,
    output logic o_out_valid,
    output t_out o_out,
    input  t_ctl i_ctl,
    output t_sts o_sts
);

    t_entry             r_book [2][BOOK_DEPTH];
    t_entry             n_book [2][BOOK_DEPTH];
    logic [CNT_W-1:0]   r_cnt [2];
    logic [CNT_W-1:0]   n_cnt [2];
    logic [CNT_W-1:0]   r_idx;
    logic [15:0]        r_next_id;
    logic [15:0]        r_oid;
    logic [15:0]        r_rem;
    t_in                r_req;
    logic               r_out_valid;
    t_out               r_out;
    t_out               n_out;
    logic [IDX_W-1:0]   ix;
    t_entry             e;
    t_entry             new_entry;
    logic [15:0]        fill_qty;
    logic [17:0]        sum_price;

    assign ix        = r_idx[IDX_W-1:0];
    assign e         = r_book[i_ctl.book][ix];
    assign fill_qty  = (r_rem < e.qty) ? r_rem : e.qty;
    assign sum_price = {1'b0, r_req.limit_price} + {1'b0, e.price};
    assign new_entry = '{id: r_oid, stock: r_req.ticker,
                         price: r_req.limit_price, qty: r_rem};

    always_comb begin
        o_sts.in_cmd   = i_in.cmd;
        o_sts.qty_zero = (r_req.order_quantity == 16'd0);
        o_sts.side     = r_req.side;
        o_sts.in_range = (r_idx < r_cnt[i_ctl.book]);
        o_sts.crosses  = r_req.side ? (r_req.limit_price <= e.price)
                                    : (r_req.limit_price >= e.price);
        o_sts.ahead    = r_req.side ? (r_req.limit_price < e.price)
                                    : (r_req.limit_price > e.price);
        o_sts.stock_eq = (e.stock == r_req.ticker);
        o_sts.id_eq    = (e.id == r_req.target_id);
        o_sts.rem_zero = (r_rem == 16'd0);
        o_sts.own_full = (r_cnt[r_req.side] >= CNT_W'(BOOK_DEPTH));
        o_sts.fill_all = (e.qty <= r_rem);
        o_sts.out_free = !r_out_valid || !i_out_stall;
    end

    always_comb begin
        n_book = r_book;
        n_cnt  = r_cnt;
        if (i_ctl.fill) begin
            n_book[i_ctl.book][ix].qty = e.qty - fill_qty;
        end
        if (i_ctl.remove) begin
            for (int k = 0; k < BOOK_DEPTH - 1; k++) begin
                if (CNT_W'(k) >= r_idx) begin
                    n_book[i_ctl.book][k] = r_book[i_ctl.book][k + 1];
                end
            end
            n_cnt[i_ctl.book] = r_cnt[i_ctl.book] - CNT_W'(1);
        end
        if (i_ctl.insert) begin
            for (int k = 1; k < BOOK_DEPTH; k++) begin
                if (CNT_W'(k) > r_idx) begin
                    n_book[i_ctl.book][k] = r_book[i_ctl.book][k - 1];
                end
            end
            n_book[i_ctl.book][ix] = new_entry;
            n_cnt[i_ctl.book] = r_cnt[i_ctl.book] + CNT_W'(1);
        end
    end

    always_comb begin
        n_out = '0;
        n_out.kind = i_ctl.kind;
        n_out.last = i_ctl.last;
        unique case (i_ctl.kind)
            KIND_ID, KIND_DONE, KIND_DROPPED: begin
                n_out.order_id       = r_oid;
                n_out.entry_stock    = r_req.ticker;
                n_out.entry_price    = {1'b0, r_req.limit_price};
                n_out.entry_quantity = (i_ctl.kind == KIND_ID) ? 16'd0 : r_rem;
                n_out.entry_side     = r_req.side;
            end
            KIND_TRADE: begin
                n_out.order_id       = r_oid;
                n_out.counter_id     = e.id;
                n_out.entry_stock    = r_req.ticker;
                n_out.entry_price    = sum_price;
                n_out.entry_quantity = fill_qty;
                n_out.entry_side     = r_req.side;
            end
            KIND_BUY_LIST, KIND_SELL_LIST, KIND_CANCELLED: begin
                n_out.order_id       = e.id;
                n_out.entry_stock    = e.stock;
                n_out.entry_price    = {1'b0, e.price};
                n_out.entry_quantity = e.qty;
                n_out.entry_side     = i_ctl.book;
            end
            KIND_LIST_END: begin
                n_out.entry_stock = r_req.ticker;
            end
            KIND_NOT_FOUND: begin
                n_out.order_id = r_req.target_id;
            end
            default: n_out.order_id = 16'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_book <= n_book;
        if (i_ctl.emit) begin
            r_out <= n_out;
        end
        if (i_ctl.load) begin
            r_req <= i_in;
            r_rem <= i_in.order_quantity;
            r_oid <= r_next_id;
        end else if (i_ctl.fill) begin
            r_rem <= r_rem - fill_qty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt[0]    <= '0;
            r_cnt[1]    <= '0;
            r_next_id   <= 16'd1;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (i_ctl.load && i_in.cmd == CMD_SUBMIT) begin
                r_next_id <= r_next_id + 16'd1;
            end
            if (i_ctl.load || i_ctl.clr) begin
                r_idx <= '0;
            end else if (i_ctl.inc) begin
                r_idx <= r_idx + CNT_W'(1);
            end
            if (i_ctl.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
`default_nettype wire

// ===== design/limit_order_book_matcher.sv =====
// Top level of the limit order book matcher.
// Instantiates lob_ctrl and lob_dp; depends on lob_pkg.
//
// Usage: commands enter on the input channel (i_in_valid, i_in, o_in_stall)
// and each transaction there causes one or more result transactions on the
// output channel (o_out_valid, o_out, i_out_stall); the final result of a
// command has its last bit set. An unknown command gives no result.
// One command is handled at a time; o_in_stall stays high until its last
// result has been loaded into the output register.
// A submit keeps the input stalled while it walks the entries of the
// opposite book and then scans its own book for the insert position; a
// dropped remainder skips the scan. A list walks both books and a cancel
// walks the buy book and then the sell book until the target id is found.
// Each book holds up to 16 entries; all these walks share the single walk
// index, and the next command is accepted in the idle state.
// Reset empties both books and sets the next order id to one.
// While the receiver stalls, the pending result holds and the command
// sequence waits before producing its next result.
`default_nettype none
module limit_order_book_matcher
    import lob_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_in_valid,
    input  t_in  i_in,
    output logic o_in_stall,
    output logic o_out_valid,
    output t_out o_out,
    input  wire  i_out_stall
);

    t_ctl ctl;
    t_sts sts;

    lob_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_ctl      (ctl)
    );

    lob_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .i_ctl       (ctl),
        .o_sts       (sts)
    );

endmodule
`default_nettype wire

// ===== tb/limit_order_book_matcher_test.sv =====
// Self-checking testbench for the limit order book matcher.
// Drives directed and random commands, predicts every result with a behavioral
// book model, and compares each result transaction; depends on lob_pkg.
`default_nettype none
module limit_order_book_matcher_test
    import lob_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    t_in  i_in = '0;
    logic i_out_stall = 1'b0;
    logic o_in_stall;
    logic o_out_valid;
    t_out o_out;

    limit_order_book_matcher dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid), .i_in(i_in),
        .o_in_stall(o_in_stall), .o_out_valid(o_out_valid), .o_out(o_out),
        .i_out_stall(i_out_stall)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_entry bids[$];
    t_entry asks[$];
    logic [15:0] id_next = 16'd1;
    t_out pending_results[$];
    int mismatches = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    function automatic t_out make_res(logic [3:0] k, logic [15:0] oid, logic [15:0] cid,
                                      logic [13:0] st, logic [17:0] pr, logic [15:0] q,
                                      logic sd);
        t_out r;
        r.kind = k; r.order_id = oid; r.counter_id = cid; r.entry_stock = st;
        r.entry_price = pr; r.entry_quantity = q; r.entry_side = sd; r.last = 1'b0;
        return r;
    endfunction

    task automatic predict_book(input t_in c);
        t_out res[$];
        t_entry e;
        logic [15:0] oid;
        logic [15:0] rem;
        logic [15:0] t;
        logic crosses;
        int i;
        bit found;
        if (c.cmd == CMD_SUBMIT) begin
            oid = id_next;
            id_next = id_next + 16'd1;
            rem = c.order_quantity;
            res.push_back(make_res(KIND_ID, oid, 0, c.ticker, c.limit_price, 0, c.side));
            i = 0;
            while (rem != 0) begin
                if (c.side == SIDE_SELL) begin
                    if (i >= bids.size()) break;
                    e = bids[i];
                    crosses = c.limit_price <= e.price;
                end else begin
                    if (i >= asks.size()) break;
                    e = asks[i];
                    crosses = c.limit_price >= e.price;
                end
                if (!crosses) break;
                if (e.stock != c.ticker) begin
                    i++;
                    continue;
                end
                t = (rem < e.qty) ? rem : e.qty;
                res.push_back(make_res(KIND_TRADE, oid, e.id, c.ticker,
                                       {1'b0, c.limit_price} + {1'b0, e.price}, t, c.side));
                rem = rem - t;
                e.qty = e.qty - t;
                if (c.side == SIDE_SELL) begin
                    if (e.qty == 0) bids.delete(i);
                    else begin bids[i] = e; i++; end
                end else begin
                    if (e.qty == 0) asks.delete(i);
                    else begin asks[i] = e; i++; end
                end
            end
            if (rem == 0) begin
                res.push_back(make_res(KIND_DONE, oid, 0, c.ticker, c.limit_price, 0,
                                       c.side));
            end else if ((c.side ? asks.size() : bids.size()) >= BOOK_DEPTH) begin
                res.push_back(make_res(KIND_DROPPED, oid, 0, c.ticker, c.limit_price,
                                       rem, c.side));
            end else begin
                e.id = oid; e.stock = c.ticker; e.price = c.limit_price; e.qty = rem;
                if (c.side == SIDE_SELL) begin
                    for (i = 0; i < asks.size(); i++) if (c.limit_price < asks[i].price) break;
                    asks.insert(i, e);
                end else begin
                    for (i = 0; i < bids.size(); i++) if (c.limit_price > bids[i].price) break;
                    bids.insert(i, e);
                end
                res.push_back(make_res(KIND_DONE, oid, 0, c.ticker, c.limit_price, rem,
                                       c.side));
            end
        end else if (c.cmd == CMD_LIST) begin
            foreach (bids[j]) if (bids[j].stock == c.ticker)
                res.push_back(make_res(KIND_BUY_LIST, bids[j].id, 0, bids[j].stock,
                                       bids[j].price, bids[j].qty, SIDE_BUY));
            foreach (asks[j]) if (asks[j].stock == c.ticker)
                res.push_back(make_res(KIND_SELL_LIST, asks[j].id, 0, asks[j].stock,
                                       asks[j].price, asks[j].qty, SIDE_SELL));
            res.push_back(make_res(KIND_LIST_END, 0, 0, c.ticker, 0, 0, 0));
        end else if (c.cmd == CMD_CANCEL) begin
            found = 0;
            for (i = 0; i < bids.size() && !found; i++) if (bids[i].id == c.target_id) begin
                e = bids[i]; bids.delete(i); found = 1;
                res.push_back(make_res(KIND_CANCELLED, e.id, 0, e.stock, e.price, e.qty,
                                       SIDE_BUY));
            end
            for (i = 0; i < asks.size() && !found; i++) if (asks[i].id == c.target_id) begin
                e = asks[i]; asks.delete(i); found = 1;
                res.push_back(make_res(KIND_CANCELLED, e.id, 0, e.stock, e.price, e.qty,
                                       SIDE_SELL));
            end
            if (!found) res.push_back(make_res(KIND_NOT_FOUND, c.target_id, 0, 0, 0, 0, 0));
        end
        if (res.size() > 0) res[res.size() - 1].last = 1'b1;
        foreach (res[j]) pending_results.push_back(res[j]);
    endtask

    // Results are checked at the edge where they are accepted.
    always @(posedge i_clk) begin
        t_out exp_r;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", o_out);
            end else begin
                exp_r = pending_results.pop_front();
                if (o_out !== exp_r) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", exp_r, o_out);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    function automatic t_in make_cmd(logic [1:0] cmd, logic [13:0] st, logic [16:0] pr,
                                     logic [15:0] q, logic sd, logic [15:0] tid);
        t_in c;
        c.cmd = cmd; c.ticker = st; c.limit_price = pr; c.order_quantity = q;
        c.side = sd; c.target_id = tid;
        return c;
    endfunction

    task automatic send_cmd(input t_in c);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in <= c;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_book(c);
    endtask

    function automatic t_in random_cmd();
        t_in c;
        int r;
        c = '0;
        r = $urandom_range(99);
        c.ticker = ($urandom_range(9) == 0) ? 14'($urandom) : 14'($urandom_range(3));
        c.limit_price = ($urandom_range(9) == 0) ? 17'($urandom) :
                        17'(1000 + $urandom_range(20));
        c.order_quantity = ($urandom_range(9) == 0) ? 16'($urandom) :
                           16'($urandom_range(50));
        c.side = 1'($urandom_range(1));
        c.target_id = ($urandom_range(3) == 0) ? 16'($urandom) :
                      id_next - 16'($urandom_range(1, 20));
        if (r < 62) c.cmd = CMD_SUBMIT;
        else if (r < 78) c.cmd = CMD_LIST;
        else if (r < 97) c.cmd = CMD_CANCEL;
        else c.cmd = 2'd3;
        return c;
    endfunction

    t_in directed[$];

    initial begin
        t_in c;
        int phase;
        int n;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed.push_back(make_cmd(CMD_LIST, 14'd0, 0, 0, 0, 0));
        directed.push_back(make_cmd(CMD_CANCEL, 0, 0, 0, 0, 16'hFFFF));
        directed.push_back(make_cmd(CMD_SUBMIT, 14'd5, 17'd0, 16'd0, SIDE_BUY, 0));
        directed.push_back(make_cmd(CMD_SUBMIT, 14'd5, 17'h1FFFF, 16'hFFFF, SIDE_BUY, 0));
        directed.push_back(make_cmd(CMD_SUBMIT, 14'd5, 17'd0, 16'd1, SIDE_BUY, 0));
        directed.push_back(make_cmd(CMD_SUBMIT, 14'h3FFF, 17'h1FFFF, 16'd7, SIDE_SELL, 0));
        directed.push_back(make_cmd(CMD_SUBMIT, 14'd5, 17'h1FFFF, 16'd10, SIDE_SELL, 0));
        directed.push_back(make_cmd(CMD_SUBMIT, 14'd5, 17'd0, 16'hFFFF, SIDE_SELL, 0));
        directed.push_back(make_cmd(CMD_LIST, 14'd5, 0, 0, 0, 0));
        directed.push_back(make_cmd(CMD_LIST, 14'h3FFF, 0, 0, 0, 0));
        directed.push_back(make_cmd(2'd3, 14'h3FFF, 17'h1FFFF, 16'hFFFF, 1, 16'hFFFF));
        directed.push_back(make_cmd(CMD_CANCEL, 0, 0, 0, 0, 16'd6));
        directed.push_back(make_cmd(CMD_CANCEL, 0, 0, 0, 0, 16'd4));
        for (int k = 0; k < 17; k++)
            directed.push_back(make_cmd(CMD_SUBMIT, 14'd9, 17'(500 + k % 3), 16'd2,
                                        SIDE_BUY, 0));
        directed.push_back(make_cmd(CMD_SUBMIT, 14'd9, 17'd400, 16'd5, SIDE_SELL, 0));
        foreach (directed[k]) send_cmd(directed[k]);

        for (phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 28 : (phase == 1) ? 63 : 0;
            recv_idle_pct = (phase == 0) ? 63 : (phase == 1) ? 28 : 0;
            for (n = 0; n < 125; n++) begin
                c = random_cmd();
                send_cmd(c);
            end
        end
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (n = 0; n < 4; n++)
            send_cmd(make_cmd(CMD_SUBMIT, 14'd8, 17'd3, 16'd1, SIDE_BUY, 0));
        send_cmd(make_cmd(CMD_LIST, 14'd8, 0, 0, 0, 0));
        send_cmd(make_cmd(CMD_CANCEL, 0, 0, 0, 0, 16'd0));
        send_cmd(make_cmd(CMD_CANCEL, 0, 0, 0, 0, 16'hFFFF));
        i_in_valid <= 1'b0;

        n = 0;
        while (pending_results.size() != 0 && n < 100000) begin
            @(posedge i_clk);
            n++;
        end
        repeat (60) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #60ms;
        $display("simulation failed");
        $finish;
    end
endmodule
`default_nettype wire

// ===== files.f =====
design/lob_pkg.sv
design/lob_ctrl.sv
design/lob_dp.sv
design/limit_order_book_matcher.sv
tb/limit_order_book_matcher_test.sv
